### rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MEM_UNITS = 256;
  localparam int ADDR_W    = $clog2(MEM_UNITS);
  localparam int PTR_W     = ADDR_W + 1;
  localparam int ORD_W     = 4;
  localparam int OWNER_W   = 8;
  localparam int REQ_W     = 9;
  localparam int FRAG_W    = 9;
  localparam logic [ORD_W-1:0] MAX_ORDER = ORD_W'(ADDR_W);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK1,
    S_M_CHK2,
    S_DONE
  } state_t;

  // one entry of the block table, valid at block start addresses
  typedef struct packed {
    logic [ORD_W-1:0]   ord;
    logic               free;
    logic [OWNER_W-1:0] owner;
    logic [REQ_W-1:0]   req;
  } entry_t;

  typedef struct packed {
    logic load;
    logic ptr_clr;
    logic ptr_next;
    logic ptr_b;
    logic rd_ptr;
    logic rd_b;
    logic save_a;
    logic split_wr;
    logic take_wr;
    logic free_wr;
    logic merge_wr;
    logic set_nospace;
    logic set_notfound;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic too_big;
    logic ptr_end;
    logic fit;
    logic split_more;
    logic owned;
    logic b_end;
    logic can_merge;
    logic out_busy;
  } sts_t;

  // smallest t with 2^t >= req, zero for a request of zero or one
  function automatic logic [ORD_W-1:0] round_order(input logic [REQ_W-1:0] req);
    logic [ORD_W-1:0] t;
    t = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (((REQ_W+1)'(1) << i) < {1'b0, req}) t = ORD_W'(i + 1);
    end
    return t;
  endfunction

  function automatic logic [ORD_W-1:0] sat_order(input logic [ORD_W-1:0] v);
    return (v > MAX_ORDER) ? MAX_ORDER : v;
  endfunction

endpackage

### rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate, free and buddy merge walks over the block table.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bba_pkg::sts_t   sts,
  output bba_pkg::cmd_t   cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_IDLE: begin
        if (in_valid) state_next = bba_pkg::S_A_RD;
      end
      bba_pkg::S_A_RD: begin
        if (sts.is_free_op) state_next = bba_pkg::S_F_RD;
        else if (sts.too_big || sts.ptr_end) state_next = bba_pkg::S_DONE;
        else state_next = bba_pkg::S_A_CHK;
      end
      bba_pkg::S_A_CHK: begin
        state_next = sts.fit ? bba_pkg::S_SPLIT : bba_pkg::S_A_RD;
      end
      bba_pkg::S_SPLIT: begin
        if (!sts.split_more) state_next = bba_pkg::S_DONE;
      end
      bba_pkg::S_F_RD: begin
        state_next = sts.ptr_end ? bba_pkg::S_M_RD : bba_pkg::S_F_CHK;
      end
      bba_pkg::S_F_CHK: begin
        state_next = sts.owned ? bba_pkg::S_M_RD : bba_pkg::S_F_RD;
      end
      bba_pkg::S_M_RD: begin
        state_next = sts.ptr_end ? bba_pkg::S_DONE : bba_pkg::S_M_CHK1;
      end
      bba_pkg::S_M_CHK1: begin
        state_next = sts.b_end ? bba_pkg::S_DONE : bba_pkg::S_M_CHK2;
      end
      bba_pkg::S_M_CHK2: begin
        state_next = bba_pkg::S_M_RD;
      end
      bba_pkg::S_DONE: begin
        if (!sts.out_busy) state_next = bba_pkg::S_IDLE;
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bba_pkg::S_A_RD: begin
        if (!sts.is_free_op) begin
          if (sts.too_big || sts.ptr_end) cmd.set_nospace = 1'b1;
          else cmd.rd_ptr = 1'b1;
        end
      end
      bba_pkg::S_A_CHK: begin
        cmd.ptr_next = !sts.fit;
      end
      bba_pkg::S_SPLIT: begin
        cmd.split_wr = sts.split_more;
        cmd.take_wr  = !sts.split_more;
      end
      bba_pkg::S_F_RD: begin
        if (sts.ptr_end) begin
          cmd.set_notfound = 1'b1;
          cmd.ptr_clr      = 1'b1;
        end else begin
          cmd.rd_ptr = 1'b1;
        end
      end
      bba_pkg::S_F_CHK: begin
        cmd.free_wr  = sts.owned;
        cmd.ptr_clr  = sts.owned;
        cmd.ptr_next = !sts.owned;
      end
      bba_pkg::S_M_RD: begin
        cmd.rd_ptr = !sts.ptr_end;
      end
      bba_pkg::S_M_CHK1: begin
        cmd.save_a = 1'b1;
        cmd.rd_b   = !sts.b_end;
      end
      bba_pkg::S_M_CHK2: begin
        cmd.merge_wr = sts.can_merge;
        cmd.ptr_clr  = sts.can_merge;
        cmd.ptr_b    = !sts.can_merge;
      end
      bba_pkg::S_DONE: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/core/bba_dpath.sv
// ----------------------------------------------------------------------------
// bba_dpath
// Block table, walk pointer, fragmentation counter and result register.
// ----------------------------------------------------------------------------
module bba_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [bba_pkg::ORD_W-1:0]    cfg_write_data,
  input  logic                         mode,
  input  logic [bba_pkg::OWNER_W-1:0]  owner_id,
  input  logic [bba_pkg::REQ_W-1:0]    request_size,
  input  bba_pkg::cmd_t                cmd,
  output bba_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [bba_pkg::ADDR_W-1:0]   block_address,
  output logic [bba_pkg::FRAG_W-1:0]   internal_frag
);

  localparam int PW = bba_pkg::PTR_W;

  bba_pkg::entry_t mem [bba_pkg::MEM_UNITS];
  bba_pkg::entry_t rd_q;
  logic [bba_pkg::ADDR_W-1:0]  rd_addr_q;

  logic [bba_pkg::ORD_W-1:0]   total_order;
  logic [bba_pkg::ORD_W-1:0]   order0;
  logic                        free0;
  logic [bba_pkg::FRAG_W-1:0]  frag;
  logic [PW-1:0]               ptr;
  logic [bba_pkg::ORD_W-1:0]   cur_o;
  logic [bba_pkg::ORD_W-1:0]   t_ord;
  logic                        mode_q;
  logic [bba_pkg::OWNER_W-1:0] owner_q;
  logic [bba_pkg::REQ_W-1:0]   req_q;
  logic [bba_pkg::ORD_W-1:0]   a_ord;
  logic                        a_free;
  bba_pkg::status_t            res_status;
  logic [bba_pkg::ADDR_W-1:0]  res_addr;

  logic [bba_pkg::ORD_W-1:0]   rd_ord;
  logic                        rd_free;
  logic [PW-1:0]               mem_size;
  logic [PW-1:0]               nxt_ptr;
  logic [PW-1:0]               b_ptr;
  logic [PW:0]                 align_mask;
  logic [bba_pkg::ORD_W-1:0]   split_o;
  logic [bba_pkg::FRAG_W-1:0]  blk_size;
  logic [bba_pkg::REQ_W-1:0]   delta_req;
  logic [bba_pkg::FRAG_W-1:0]  frag_delta;

  logic                        wr_en;
  logic [bba_pkg::ADDR_W-1:0]  wr_addr;
  bba_pkg::entry_t             wr_data;
  logic [bba_pkg::ADDR_W-1:0]  rd_addr;

  // entry zero's order and free flag live in flops so reset needs no sweep
  assign rd_ord  = (rd_addr_q == '0) ? order0 : rd_q.ord;
  assign rd_free = (rd_addr_q == '0) ? free0  : rd_q.free;

  assign mem_size   = PW'(1) << total_order;
  assign nxt_ptr    = ptr + (PW'(1) << rd_ord);
  assign b_ptr      = ptr + (PW'(1) << a_ord);
  assign align_mask = ((PW+1)'(2) << a_ord) - (PW+1)'(1);
  assign split_o    = cur_o - bba_pkg::ORD_W'(1);
  assign blk_size   = bba_pkg::FRAG_W'(1) << (cmd.take_wr ? t_ord : rd_ord);
  // a free gives back the slack recorded when the block was taken
  assign delta_req  = cmd.take_wr ? req_q : rd_q.req;
  assign frag_delta = (delta_req == '0) ? '0 : blk_size - bba_pkg::FRAG_W'(delta_req);

  assign sts.is_free_op = mode_q;
  assign sts.too_big    = t_ord > total_order;
  assign sts.ptr_end    = ptr >= mem_size;
  assign sts.fit        = rd_free && (rd_ord >= t_ord);
  assign sts.split_more = cur_o > t_ord;
  assign sts.owned      = !rd_free && (rd_q.owner == owner_q);
  assign sts.b_end      = nxt_ptr >= mem_size;
  assign sts.can_merge  = a_free && rd_free && (rd_ord == a_ord) &&
                          ((ptr & align_mask[PW-1:0]) == '0);
  assign sts.out_busy   = out_valid && !out_ready;

  assign rd_addr = cmd.rd_b ? nxt_ptr[bba_pkg::ADDR_W-1:0] : ptr[bba_pkg::ADDR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr[bba_pkg::ADDR_W-1:0];
    wr_data = rd_q;
    if (cmd.split_wr) begin
      wr_en        = 1'b1;
      wr_addr      = bba_pkg::ADDR_W'(ptr + (PW'(1) << split_o));
      wr_data.ord  = split_o;
      wr_data.free = 1'b1;
    end else if (cmd.take_wr) begin
      wr_en         = 1'b1;
      wr_data.ord   = t_ord;
      wr_data.free  = 1'b0;
      wr_data.owner = owner_q;
      wr_data.req   = req_q;
    end else if (cmd.free_wr) begin
      wr_en        = 1'b1;
      wr_data.ord  = rd_ord;
      wr_data.free = 1'b1;
    end else if (cmd.merge_wr) begin
      wr_en        = 1'b1;
      wr_data.ord  = a_ord + bba_pkg::ORD_W'(1);
      wr_data.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_ptr || cmd.rd_b) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      owner_q <= owner_id;
      req_q   <= request_size;
      t_ord   <= bba_pkg::round_order(request_size);
    end
    if (cmd.load || cmd.ptr_clr) ptr <= '0;
    else if (cmd.ptr_next) ptr <= nxt_ptr;
    else if (cmd.ptr_b) ptr <= b_ptr;
    if (cmd.save_a) begin
      a_ord  <= rd_ord;
      a_free <= rd_free;
    end
    if (cmd.ptr_next == 1'b0 && sts.fit) cur_o <= rd_ord;
    if (cmd.split_wr) cur_o <= split_o;
    if (cmd.load) begin
      res_status <= bba_pkg::ST_OK;
      res_addr   <= '0;
    end
    if (cmd.set_nospace) res_status <= bba_pkg::ST_NO_SPACE;
    if (cmd.set_notfound) res_status <= bba_pkg::ST_NOT_FOUND;
    if (cmd.take_wr) res_addr <= ptr[bba_pkg::ADDR_W-1:0];
    if (cmd.out_load) begin
      status        <= res_status;
      block_address <= res_addr;
      internal_frag <= frag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_order <= bba_pkg::MAX_ORDER;
      order0      <= bba_pkg::MAX_ORDER;
      free0       <= 1'b1;
      frag        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        total_order <= bba_pkg::sat_order(cfg_write_data);
        order0      <= bba_pkg::sat_order(cfg_write_data);
        free0       <= 1'b1;
        frag        <= '0;
      end else begin
        if (wr_en && wr_addr == '0) begin
          order0 <= wr_data.ord;
          free0  <= wr_data.free;
        end
        if (cmd.take_wr) frag <= frag + frag_delta;
        else if (cmd.free_wr) frag <= frag - frag_delta;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> (frag == '0) && free0 && (order0 == total_order))
    else $error("config write did not reinitialize the table");

  a_split_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.split_wr |-> (cur_o > t_ord) && (t_ord <= total_order))
    else $error("split below the rounded order");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_ptr || cmd.rd_b) |-> (ptr < mem_size))
    else $error("table read past the managed memory");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.take_wr |-> !mode_q)
    else $error("block taken during a free request");

endmodule

### rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over 2^total_order units with a per-unit block table.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. Latency depends on the table
// contents: an allocate walks the blocks until one fits, then splits it down to
// the rounded order; a free walks the blocks to find one held by the owner,
// then runs a merge walk over the blocks, restarting after each merge. The
// block table takes one read and one write per cycle.
// No clearing pass follows reset or a total_order write.
module buddy_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [bba_pkg::ORD_W-1:0]    cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [bba_pkg::OWNER_W-1:0]  owner_id,
  input  logic [bba_pkg::REQ_W-1:0]    request_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [bba_pkg::ADDR_W-1:0]   block_address,
  output logic [bba_pkg::FRAG_W-1:0]   internal_frag
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mode           (mode),
    .owner_id       (owner_id),
    .request_size   (request_size),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .block_address  (block_address),
    .internal_frag  (internal_frag)
  );

endmodule
